### rtl/uvs_pkg.sv
// Shared types and constants of the UV sphere vertex generator.
package uvs_pkg;

	localparam int NUM_W     = 41;
	localparam int REM_W     = 9;
	localparam int QUO_W     = 33;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_LANES = 4;
	localparam int CW        = 34;

	localparam logic [0:0] CFG_RADIUS     = 1'b0;
	localparam logic [0:0] CFG_RESOLUTION = 1'b1;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TURNS [0:23] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] num;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		logic [REM_W-1:0]                divisor;
		div_lane_t [DIV_LANES-1:0]       lanes;
	} div_stage_t;

	typedef struct packed {
		logic                 flip;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cord_t;

	typedef struct packed {
		logic [16:0] vidx;
		logic [16:0] below;
		logic        quad;
	} side_t;

	typedef struct packed {
		logic [16:0] u;
		logic [16:0] v;
	} tex_t;

endpackage

### rtl/uvs_div_cell.sv
// One restoring division step for all four quotient lanes.
module uvs_div_cell (
	input  logic               clk,
	input  logic               en,
	input  uvs_pkg::div_stage_t d_in,
	output uvs_pkg::div_stage_t d_out
);

	uvs_pkg::div_stage_t nxt;
	logic [uvs_pkg::REM_W:0] trial [uvs_pkg::DIV_LANES];
	logic [uvs_pkg::DIV_LANES-1:0] ge;

	always_comb begin
		nxt.divisor = d_in.divisor;
		for (int k = 0; k < uvs_pkg::DIV_LANES; k++) begin
			trial[k] = {d_in.lanes[k].rem, d_in.lanes[k].num[uvs_pkg::NUM_W-1]};
			ge[k] = (trial[k] >= {1'b0, d_in.divisor});
			if (ge[k]) begin
				nxt.lanes[k].rem = uvs_pkg::REM_W'(trial[k] - {1'b0, d_in.divisor});
			end else begin
				nxt.lanes[k].rem = trial[k][uvs_pkg::REM_W-1:0];
			end
			nxt.lanes[k].num = {d_in.lanes[k].num[uvs_pkg::NUM_W-2:0], 1'b0};
			nxt.lanes[k].quo = {d_in.lanes[k].quo[uvs_pkg::QUO_W-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

### rtl/uvs_cordic_cell.sv
// One CORDIC rotation step in binary-angle units.
module uvs_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  logic           en,
	input  uvs_pkg::cord_t c_in,
	output uvs_pkg::cord_t c_out
);

	uvs_pkg::cord_t nxt;
	logic signed [uvs_pkg::CW-1:0] dx;
	logic signed [uvs_pkg::CW-1:0] dy;
	logic signed [uvs_pkg::CW-1:0] ang;

	always_comb begin
		dx  = c_in.y >>> STAGE;
		dy  = c_in.x >>> STAGE;
		ang = $signed({2'b00, uvs_pkg::ATAN_TURNS[STAGE]});
		nxt.flip = c_in.flip;
		if (!c_in.z[uvs_pkg::CW-1]) begin
			nxt.x = c_in.x - dx;
			nxt.y = c_in.y + dy;
			nxt.z = c_in.z - ang;
		end else begin
			nxt.x = c_in.x + dx;
			nxt.y = c_in.y - dy;
			nxt.z = c_in.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_out <= nxt;
		end
	end

endmodule

### rtl/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator.
// Takes one grid point per clock and returns one vertex per clock while in_stall is low.
// The pipeline is a 41-cell chain of restoring division steps (polar angle, azimuth
// and both texture coordinates side by side), followed by two CORDIC chains of
// CORDIC_STAGES cells and five stages of rounding and multiplication. The
// whole pipeline advances together; in_stall rises only while a finished vertex waits at
// the output under out_stall. Radius and resolution must be written while the block is idle.
module uv_sphere_vertex_generator #(
	parameter int MAX_RESOLUTION = 256,
	parameter int CORDIC_STAGES  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [8:0]         lat_step,
	input  logic [8:0]         lon_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [16:0]        vertex_index,
	output logic [16:0]        below_index,
	output logic               quad_valid
);

	localparam int SIDE_DLY = 46 + CORDIC_STAGES;
	localparam int TEX_DLY  = 4 + CORDIC_STAGES;

	function automatic uvs_pkg::cord_t cord_prep(input logic [31:0] ang);
		uvs_pkg::cord_t c;
		logic [31:0] sum;
		logic [31:0] z;
		sum = ang + 32'h40000000;
		z   = sum[31] ? (ang ^ 32'h80000000) : ang;
		c.flip = sum[31];
		c.x = uvs_pkg::CORDIC_GAIN;
		c.y = '0;
		c.z = $signed({{2{z[31]}}, z});
		return c;
	endfunction

	function automatic logic signed [15:0] clamp_q14(input logic signed [18:0] r);
		logic signed [15:0] o;
		if (r > 19'sd16384) begin
			o = 16'sd16384;
		end else if (r < -19'sd16384) begin
			o = -16'sd16384;
		end else begin
			o = r[15:0];
		end
		return o;
	endfunction

	function automatic logic signed [15:0] cord_round(input logic signed [33:0] v,
		input logic flip);
		logic signed [33:0] f;
		logic signed [34:0] s;
		f = flip ? -v : v;
		s = {f[33], f} + 35'sd32768;
		return clamp_q14(s[34:16]);
	endfunction

	function automatic logic signed [15:0] prod_round(input logic signed [31:0] p);
		logic signed [31:0] s;
		s = p + 32'sd8192;
		return clamp_q14({{1{s[31]}}, s[31:14]});
	endfunction

	// Configuration registers.
	logic [15:0] radius_q;
	logic [8:0]  resolution_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= 16'd256;
			resolution_q <= 9'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uvs_pkg::CFG_RADIUS:     radius_q     <= cfg_data;
				uvs_pkg::CFG_RESOLUTION: resolution_q <= cfg_data[8:0];
				default:                 radius_q     <= radius_q;
			endcase
		end
	end

	logic adv;
	logic out_vld_q;
	assign adv       = !(out_vld_q && out_stall);
	assign in_stall  = !adv;
	assign out_valid = out_vld_q;

	// Input preparation.
	logic [8:0]  res_c;
	logic [8:0]  lat_c;
	logic [8:0]  lon_c;
	logic [8:0]  half_res;
	logic [9:0]  res_p1;
	logic [19:0] vidx_w;
	logic [19:0] below_w;
	uvs_pkg::div_stage_t prep;
	uvs_pkg::side_t      side_c;

	always_comb begin
		if (resolution_q == 9'd0) begin
			res_c = 9'd1;
		end else if (int'(resolution_q) > MAX_RESOLUTION) begin
			res_c = 9'(MAX_RESOLUTION);
		end else begin
			res_c = resolution_q;
		end
		lat_c    = (lat_step > res_c) ? res_c : lat_step;
		lon_c    = (lon_step > res_c) ? res_c : lon_step;
		half_res = res_c >> 1;
		res_p1   = {1'b0, res_c} + 10'd1;
		vidx_w   = {11'd0, lat_c} * {10'd0, res_p1} + {11'd0, lon_c};
		below_w  = vidx_w + {10'd0, res_p1};

		prep.divisor = res_c;
		for (int k = 0; k < uvs_pkg::DIV_LANES; k++) begin
			prep.lanes[k].rem = '0;
			prep.lanes[k].quo = '0;
		end
		prep.lanes[0].num = {1'b0, lat_c, 31'd0} | {32'd0, half_res};
		prep.lanes[1].num = {lon_c, 32'd0} | {32'd0, half_res};
		prep.lanes[2].num = {16'd0, lon_c, 16'd0} | {32'd0, half_res};
		prep.lanes[3].num = {16'd0, lat_c, 16'd0} | {32'd0, half_res};

		side_c.vidx  = vidx_w[16:0];
		side_c.below = (lat_c < res_c) ? below_w[16:0] : 17'd0;
		side_c.quad  = (lat_c < res_c) && (lon_c < res_c);
	end

	uvs_pkg::div_stage_t div_bus [0:uvs_pkg::DIV_STEPS];
	uvs_pkg::side_t      side_s1;
	logic                vld_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_bus[0] <= prep;
			side_s1    <= side_c;
		end
	end

	for (genvar g = 0; g < uvs_pkg::DIV_STEPS; g++) begin : g_div
		uvs_div_cell u_cell (
			.clk  (clk),
			.en   (adv),
			.d_in (div_bus[g]),
			.d_out(div_bus[g+1])
		);
	end

	// Angles and texture coordinates from the quotients.
	uvs_pkg::cord_t th_bus [0:CORDIC_STAGES];
	uvs_pkg::cord_t ph_bus [0:CORDIC_STAGES];
	uvs_pkg::tex_t  tex_c0_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			th_bus[0]  <= cord_prep(div_bus[uvs_pkg::DIV_STEPS].lanes[0].quo[31:0]);
			ph_bus[0]  <= cord_prep(div_bus[uvs_pkg::DIV_STEPS].lanes[1].quo[31:0]);
			tex_c0_q.u <= div_bus[uvs_pkg::DIV_STEPS].lanes[2].quo[16:0];
			tex_c0_q.v <= 17'd65536 - div_bus[uvs_pkg::DIV_STEPS].lanes[3].quo[16:0];
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		uvs_cordic_cell #(.STAGE(g)) u_th (
			.clk  (clk),
			.en   (adv),
			.c_in (th_bus[g]),
			.c_out(th_bus[g+1])
		);
		uvs_cordic_cell #(.STAGE(g)) u_ph (
			.clk  (clk),
			.en   (adv),
			.c_in (ph_bus[g]),
			.c_out(ph_bus[g+1])
		);
	end

	// Rounding, normals and positions.
	logic signed [15:0] ct_q, st_q, cp_q, sp_q;
	logic signed [31:0] pxy_q, pyy_q;
	logic signed [15:0] ctm_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic signed [33:0] qx_q, qy_q, qz_q;
	logic signed [15:0] nxp_q, nyp_q, nzp_q;
	logic signed [16:0] rad_s;
	logic signed [33:0] sx, sy, sz;

	assign rad_s = $signed({1'b0, radius_q});
	assign sx = qx_q + 34'sd8192;
	assign sy = qy_q + 34'sd8192;
	assign sz = qz_q + 34'sd8192;

	always_ff @(posedge clk) begin
		if (adv) begin
			ct_q  <= cord_round(th_bus[CORDIC_STAGES].x, th_bus[CORDIC_STAGES].flip);
			st_q  <= cord_round(th_bus[CORDIC_STAGES].y, th_bus[CORDIC_STAGES].flip);
			cp_q  <= cord_round(ph_bus[CORDIC_STAGES].x, ph_bus[CORDIC_STAGES].flip);
			sp_q  <= cord_round(ph_bus[CORDIC_STAGES].y, ph_bus[CORDIC_STAGES].flip);
			pxy_q <= st_q * cp_q;
			pyy_q <= st_q * sp_q;
			ctm_q <= ct_q;
			nx_q  <= prod_round(pxy_q);
			ny_q  <= prod_round(pyy_q);
			nz_q  <= ctm_q;
			qx_q  <= rad_s * nx_q;
			qy_q  <= rad_s * ny_q;
			qz_q  <= rad_s * nz_q;
			nxp_q <= nx_q;
			nyp_q <= ny_q;
			nzp_q <= nz_q;
		end
	end

	// Side data and valid flags follow the datapath.
	uvs_pkg::side_t side_dly_q [0:SIDE_DLY-1];
	logic           vld_dly_q  [0:SIDE_DLY-1];
	uvs_pkg::tex_t  tex_dly_q  [0:TEX_DLY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < SIDE_DLY; i++) begin
				vld_dly_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1       <= in_valid;
			vld_dly_q[0] <= vld_s1;
			for (int i = 1; i < SIDE_DLY; i++) begin
				vld_dly_q[i] <= vld_dly_q[i-1];
			end
			out_vld_q <= vld_dly_q[SIDE_DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dly_q[0] <= side_s1;
			for (int i = 1; i < SIDE_DLY; i++) begin
				side_dly_q[i] <= side_dly_q[i-1];
			end
			tex_dly_q[0] <= tex_c0_q;
			for (int i = 1; i < TEX_DLY; i++) begin
				tex_dly_q[i] <= tex_dly_q[i-1];
			end
			pos_x        <= sx[30:14];
			pos_y        <= sy[30:14];
			pos_z        <= sz[30:14];
			norm_x       <= nxp_q;
			norm_y       <= nyp_q;
			norm_z       <= nzp_q;
			tex_u        <= tex_dly_q[TEX_DLY-1].u;
			tex_v        <= tex_dly_q[TEX_DLY-1].v;
			vertex_index <= side_dly_q[SIDE_DLY-1].vidx;
			below_index  <= side_dly_q[SIDE_DLY-1].below;
			quad_valid   <= side_dly_q[SIDE_DLY-1].quad;
		end
	end

endmodule

### tb/uv_sphere_vertex_generator_tb.sv
// Self-checking testbench of the UV sphere vertex generator.
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_tb;

	localparam int MAX_RES = 256;
	localparam int STAGES = 16;
	localparam int LATENCY = 47 + STAGES;
	localparam int HOLD_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [16:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [16:0] u, v, vidx, below;
		logic quad;
	} vertex_t;

	// Floor shift for signed values.
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp14(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
			output longint s);
		logic [31:0] z;
		logic flip;
		longint zs, x, y, dx, dy;
		z = ang;
		flip = 1'b0;
		if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
			z = ang - 32'h80000000;
			flip = 1'b1;
		end
		zs = longint'(signed'(z));
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (zs >= 0) begin
				x -= dx; y += dy; zs -= longint'(uvs_pkg::ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; zs += longint'(uvs_pkg::ATAN_TURNS[i]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = clamp14(shr_floor(x + 32768, 16));
		s = clamp14(shr_floor(y + 32768, 16));
	endfunction

	class vertex_scoreboard;
		longint unsigned rad, res_reg;
		vertex_t pending[$];
		int errors, checked;

		function vertex_t predict(longint unsigned lat_in, longint unsigned lon_in);
			vertex_t e;
			longint unsigned res, lat, lon, vidx;
			logic [31:0] theta, phi;
			longint ct, st, cp, sp, nx, ny;
			res = res_reg;
			if (res == 0) res = 1;
			if (res > MAX_RES) res = MAX_RES;
			lat = lat_in > res ? res : lat_in;
			lon = lon_in > res ? res : lon_in;
			theta = 32'(((lat << 32) + res) / (2 * res));
			phi = 32'(((lon << 33) + res) / (2 * res));
			cordic_sincos(theta, ct, st);
			cordic_sincos(phi, cp, sp);
			nx = clamp14(shr_floor(st * cp + 8192, 14));
			ny = clamp14(shr_floor(st * sp + 8192, 14));
			e.px = 17'(shr_floor(longint'(rad) * nx + 8192, 14));
			e.py = 17'(shr_floor(longint'(rad) * ny + 8192, 14));
			e.pz = 17'(shr_floor(longint'(rad) * ct + 8192, 14));
			e.nx = 16'(nx);
			e.ny = 16'(ny);
			e.nz = 16'(ct);
			e.u = 17'((lon * 65536 + res / 2) / res);
			e.v = 17'(65536 - (lat * 65536 + res / 2) / res);
			vidx = lat * (res + 1) + lon;
			e.vidx = 17'(vidx);
			e.below = (lat < res) ? 17'(vidx + res + 1) : 17'd0;
			e.quad = (lat < res && lon < res);
			return e;
		endfunction

		function void note_input(logic [8:0] lat, logic [8:0] lon);
			pending = {pending, predict(lat, lon)};
		endfunction

		function void check_result(vertex_t got);
			vertex_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected vertex, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("pos_x", e.px, got.px); cmp("pos_y", e.py, got.py);
			cmp("pos_z", e.pz, got.pz); cmp("norm_x", e.nx, got.nx);
			cmp("norm_y", e.ny, got.ny); cmp("norm_z", e.nz, got.nz);
			cmp("tex_u", e.u, got.u); cmp("tex_v", e.v, got.v);
			cmp("vertex_index", e.vidx, got.vidx);
			cmp("below_index", e.below, got.below);
			cmp("quad_valid", e.quad, got.quad);
		endfunction

		function void cmp(string name, longint e, longint a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = uvs_pkg::CFG_RADIUS;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [8:0] lat_step = '0, lon_step = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic [16:0] tex_u, tex_v, vertex_index, below_index;
	logic quad_valid;

	vertex_scoreboard sb = new();
	int idle_pct = 24;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_off = 0;
	int sent = 0;
	longint cycles = 0;

	uv_sphere_vertex_generator #(.MAX_RESOLUTION(MAX_RES), .CORDIC_STAGES(STAGES)) i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
		.lat_step, .lon_step, .out_valid, .out_stall, .pos_x, .pos_y, .pos_z,
		.norm_x, .norm_y, .norm_z, .tex_u, .tex_v, .vertex_index, .below_index,
		.quad_valid
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, or a long counted hold-off on request.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result('{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
				tex_u, tex_v, vertex_index, below_index, quad_valid});
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_off <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == uvs_pkg::CFG_RADIUS) sb.rad = val;
		else sb.res_reg = val & 16'h1FF;
		@(posedge clk);
	endtask

	// Offers one grid point, with a random gap first, and waits for its transfer.
	task automatic send_point(logic [8:0] lat, logic [8:0] lon);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		lat_step <= lat;
		lon_step <= lon;
		do @(posedge clk); while (in_stall);
		sb.note_input(lat, lon);
		sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [8:0] pick_step(int res);
		int r;
		r = $urandom_range(99);
		if (r < 80) return 9'($urandom_range(res));
		if (r < 90) return 9'(res);
		return 9'($urandom_range(511));
	endfunction

	task automatic random_phase(int count, int res);
		for (int k = 0; k < count; k++)
			send_point(pick_step(res), pick_step(res));
	endtask

	initial begin
		sb.rad = 256;
		sb.res_reg = 32;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, poles, seam, clamping and the field extremes.
		send_point(0, 0); send_point(32, 32); send_point(16, 8); send_point(31, 31);
		send_point(511, 511); send_point(33, 0); send_point(0, 511);
		send_point(9'h155, 9'h0AA); send_point(9'h0AA, 9'h155);
		drain();
		write_reg(uvs_pkg::CFG_RADIUS, 16'hFFFF);
		write_reg(uvs_pkg::CFG_RESOLUTION, 9'd256);
		send_point(0, 0); send_point(128, 64); send_point(256, 256); send_point(255, 255);
		send_point(300, 100); send_point(64, 192);
		drain();
		write_reg(uvs_pkg::CFG_RADIUS, 16'd0);
		write_reg(uvs_pkg::CFG_RESOLUTION, 9'd0);
		send_point(0, 0); send_point(1, 1); send_point(5, 2);
		drain();
		write_reg(uvs_pkg::CFG_RADIUS, 16'd1);
		write_reg(uvs_pkg::CFG_RESOLUTION, 9'h1FF);
		send_point(256, 0); send_point(100, 511); send_point(511, 3);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			int res;
			res = (ph == 0) ? 1 : (ph == 1) ? 256 : $urandom_range(1, 300);
			write_reg(uvs_pkg::CFG_RADIUS,
				(ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
			write_reg(uvs_pkg::CFG_RESOLUTION, 16'(res));
			if (res > MAX_RES) res = MAX_RES;
			idle_pct = (ph == 3) ? 0 : 24;
			if (ph == 4) hold_req++;
			random_phase(160, res);
			drain();
		end
		idle_pct = 24;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d grid points over 12 settings, checked %0d vertices.",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### uv_sphere_vertex_generator.f
rtl/uvs_pkg.sv
rtl/uvs_div_cell.sv
rtl/uvs_cordic_cell.sv
rtl/uv_sphere_vertex_generator.sv
tb/uv_sphere_vertex_generator_tb.sv
